// ----- rtl/core/lacc_pkg.sv -----
`timescale 1ns / 1ps

package lacc_pkg;

  // Field and arithmetic widths
  localparam int FIELD_W        = 16;  // angle fields, 2^16 per turn
  localparam int ANGLE_BITS_DEF = 16;  // internal angle resolution per turn
  localparam int Q_BITS         = 30;  // fraction bits of the trig values
  localparam int MAG_W          = Q_BITS + 1;  // magnitude up to 1.0 in Q30
  localparam int SEP_W          = 18;  // signed Q1.16 result
  localparam int SEP_FRAC       = 16;
  localparam int ROUND_SHIFT    = Q_BITS - SEP_FRAC;
  localparam int SUM_W          = MAG_W + 2;  // signed sum of two Q30 terms

  // Digit-serial multiplier: operand B consumed one digit per cycle
  localparam int MUL_OP_W    = 32;
  localparam int MUL_DIGIT_W = 8;
  localparam int MUL_DIGITS  = MUL_OP_W / MUL_DIGIT_W;
  localparam int ACC_W       = MAG_W + (MUL_OP_W - Q_BITS);

  // Sequencer
  localparam int N_ANGLES   = 5;  // sin el_l, sin el_a, cos el_l, cos el_a, cos daz
  localparam int IDX_W      = $clog2(N_ANGLES);
  localparam int K_W        = 3;
  localparam int POLY_TOP   = 5;  // highest Horner coefficient

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic REG_COS_LIMIT = 1'b0;
  localparam logic signed [SEP_W-1:0] COS_LIMIT_RST = 18'sd65536;
  localparam logic signed [SEP_W-1:0] SEP_ONE       = 18'sd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_ISSUE,
    ST_WAIT,
    ST_ROUND,
    ST_FINAL
  } lacc_state_t;

  typedef enum logic [2:0] {
    STEP_SQUARE,
    STEP_HORNER,
    STEP_PROD_S,
    STEP_PROD_C,
    STEP_PROD_CC
  } lacc_step_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } lacc_mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] prod;
  } lacc_mul_rsp_t;

  // Q30 coefficients of cos over the first quadrant, Horner on t^2
  function automatic logic [MAG_W-1:0] cos_coef(input logic [K_W-1:0] k);
    logic [MAG_W-1:0] c;
    unique case (k)
      3'd0:    c = 31'd1073741824;
      3'd1:    c = 31'd1324675879;
      3'd2:    c = 31'd272375560;
      3'd3:    c = 31'd22401992;
      3'd4:    c = 31'd987048;
      3'd5:    c = 31'd27061;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/lacc_if.sv -----
`timescale 1ns / 1ps

// Input channel: one aircraft per transfer
interface lacc_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] laser_az;
  logic signed [15:0] laser_el;
  logic        [15:0] aircraft_az;
  logic signed [15:0] aircraft_el;
  logic               first_of_scan;
  logic               last_of_scan;

  modport source (
    output valid, laser_az, laser_el, aircraft_az, aircraft_el, first_of_scan, last_of_scan,
    input  ready
  );
  modport sink (
    input  valid, laser_az, laser_el, aircraft_az, aircraft_el, first_of_scan, last_of_scan,
    output ready
  );
endinterface

// Output channel: one result per transfer
interface lacc_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] separation_cos;
  logic               aircraft_danger;
  logic               scan_danger;
  logic               scan_done;

  modport source (
    output valid, separation_cos, aircraft_danger, scan_danger, scan_done,
    input  ready
  );
  modport sink (
    input  valid, separation_cos, aircraft_danger, scan_danger, scan_done,
    output ready
  );
endinterface

// ----- rtl/core/lacc_mul.sv -----
`timescale 1ns / 1ps

// Digit-serial Q30 multiplier: prod = floor(a * b / 2^30).
// A is pre-scaled by the surplus of the operand width over Q30, B is
// consumed LSB digit first and the accumulator shifts right each digit,
// so the low bits drop out exactly as a floor.
module lacc_mul
  import lacc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  lacc_mul_req_t req,
  output lacc_mul_rsp_t rsp
);

  localparam int PART_W = ACC_W + MUL_DIGIT_W;
  localparam int CNT_W  = $clog2(MUL_DIGITS);

  logic [ACC_W-1:0]    a_sh;
  logic [MUL_OP_W-1:0] b_sr;
  logic [ACC_W-1:0]    acc;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [PART_W-1:0]   part;
  logic [PART_W-1:0]   sum;

  // one digit of partial product per cycle
  always_comb begin
    part = PART_W'(a_sh) * PART_W'(b_sr[MUL_DIGIT_W-1:0]);
    sum  = PART_W'(acc) + part;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_sh <= {req.a, {(MUL_OP_W - Q_BITS){1'b0}}};
      b_sr <= MUL_OP_W'(req.b);
      acc  <= '0;
    end else if (busy) begin
      acc  <= sum[PART_W-1:MUL_DIGIT_W];
      b_sr <= b_sr >> MUL_DIGIT_W;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc[MAG_W-1:0];

endmodule

// ----- rtl/core/lacc_apb.sv -----
`timescale 1ns / 1ps

// Configuration registers: cos_limit only
module lacc_apb
  import lacc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  output logic signed [SEP_W-1:0]       cos_limit
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1];
  assign wr_en   = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_limit <= COS_LIMIT_RST;
    end else if (wr_en && (reg_idx == REG_COS_LIMIT)) begin
      cos_limit <= pwdata[SEP_W-1:0];
    end
  end

  // read back, sign-extended
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_COS_LIMIT) begin
      prdata = APB_DATA_W'(cos_limit);
    end
  end

endmodule

// ----- rtl/core/lacc_core.sv -----
`timescale 1ns / 1ps

// Sequencer: five trig evaluations by Horner on the shared multiplier,
// three signed products, rounding, threshold and the sticky scan flag.
module lacc_core
  import lacc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  lacc_in_if.sink                 in_ch,
  lacc_out_if.source              out_ch,
  input  logic signed [SEP_W-1:0] cos_limit
);

  localparam int T_PAD = MAG_W - (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS-1:0] QTURN   = {2'b01, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic [ANGLE_BITS-2:0] QUARTER = {1'b1, {(ANGLE_BITS - 2){1'b0}}};
  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(1) <<< (ROUND_SHIFT - 1);
  localparam int SH_W = SUM_W - ROUND_SHIFT;
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(SEP_ONE);
  localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(SEP_ONE);

  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [FIELD_W-1:0] v);
    logic [ANGLE_BITS+FIELD_W-1:0] w;
    w = {v, {ANGLE_BITS{1'b0}}};
    return w[ANGLE_BITS+FIELD_W-1:FIELD_W];
  endfunction

  lacc_state_t state, state_next;
  lacc_step_t  step, step_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [K_W-1:0]   k, k_next;
  logic             danger_seen, danger_seen_next;
  logic             out_valid, out_valid_next;

  logic [ANGLE_BITS-1:0] ang [N_ANGLES];
  logic [MAG_W-1:0]      res_mag [N_ANGLES];
  logic                  res_neg [N_ANGLES];
  logic [MAG_W-1:0]      op_a, op_b, u;
  logic                  qneg;
  logic [MAG_W-1:0]      s_mag, c_mag;
  logic                  s_neg, c_neg;
  logic signed [SEP_W-1:0] sep;
  logic                  first_q, last_q;
  logic signed [SEP_W-1:0] out_sep;
  logic                  out_ad, out_sd, out_done;

  lacc_mul_req_t mul_req;
  lacc_mul_rsp_t mul_rsp;

  logic [ANGLE_BITS-1:0] la_lel, la_ael, la_laz, la_aaz;
  logic [1:0]            quad;
  logic [ANGLE_BITS-2:0] arg;
  logic [MAG_W-1:0]      t_arg;
  logic [MAG_W-1:0]      coef_k, p_new;
  logic                  in_xfer, out_load, aircraft_hit;
  logic signed [SUM_W-1:0] s_val, c_val, sum;
  logic signed [SH_W-1:0]  shifted;
  logic signed [SEP_W-1:0] sep_sat;

  lacc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // input angles rescaled to the internal resolution
  always_comb begin
    la_laz = to_angle(in_ch.laser_az);
    la_lel = to_angle(in_ch.laser_el);
    la_aaz = to_angle(in_ch.aircraft_az);
    la_ael = to_angle(in_ch.aircraft_el);
  end

  // quadrant reduction of the head angle to t in Q30
  always_comb begin
    quad  = ang[0][ANGLE_BITS-1:ANGLE_BITS-2];
    arg   = {1'b0, ang[0][ANGLE_BITS-3:0]};
    if (quad[0]) begin
      arg = QUARTER - arg;
    end
    t_arg = {arg, {T_PAD{1'b0}}};
  end

  // Horner step, floored at zero
  always_comb begin
    coef_k = cos_coef(k);
    p_new  = (coef_k > mul_rsp.prod) ? coef_k - mul_rsp.prod : '0;
  end

  // final sum, rounding to Q1.16 and saturation
  always_comb begin
    s_val   = s_neg ? -$signed(SUM_W'(s_mag)) : $signed(SUM_W'(s_mag));
    c_val   = c_neg ? -$signed(SUM_W'(c_mag)) : $signed(SUM_W'(c_mag));
    sum     = s_val + c_val + RND;
    shifted = sum[SUM_W-1:ROUND_SHIFT];
    if (shifted > SAT_HI) begin
      sep_sat = SEP_ONE;
    end else if (shifted < SAT_LO) begin
      sep_sat = -SEP_ONE;
    end else begin
      sep_sat = shifted[SEP_W-1:0];
    end
  end

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign aircraft_hit = sep > cos_limit;

  // next state and outputs
  always_comb begin
    state_next       = state;
    step_next        = step;
    idx_next         = idx;
    k_next           = k;
    danger_seen_next = danger_seen;
    out_load         = 1'b0;
    in_ch.ready      = 1'b0;
    mul_req          = '{start: 1'b0, a: op_a, b: op_b};

    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          idx_next   = '0;
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        mul_req    = '{start: 1'b1, a: t_arg, b: t_arg};
        step_next  = STEP_SQUARE;
        state_next = ST_WAIT;
      end
      ST_ISSUE: begin
        mul_req.start = 1'b1;
        state_next    = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp.done) begin
          unique case (step)
            STEP_SQUARE: begin
              k_next     = K_W'(POLY_TOP - 1);
              step_next  = STEP_HORNER;
              state_next = ST_ISSUE;
            end
            STEP_HORNER: begin
              if (k != '0) begin
                k_next     = k - K_W'(1);
                state_next = ST_ISSUE;
              end else if (idx == IDX_W'(N_ANGLES - 1)) begin
                step_next  = STEP_PROD_S;
                state_next = ST_ISSUE;
              end else begin
                idx_next   = idx + IDX_W'(1);
                state_next = ST_ANGLE;
              end
            end
            STEP_PROD_S: begin
              step_next  = STEP_PROD_C;
              state_next = ST_ISSUE;
            end
            STEP_PROD_C: begin
              step_next  = STEP_PROD_CC;
              state_next = ST_ISSUE;
            end
            STEP_PROD_CC: begin
              state_next = ST_ROUND;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_ROUND: begin
        state_next = ST_FINAL;
      end
      ST_FINAL: begin
        if (!out_valid || out_ch.ready) begin
          out_load         = 1'b1;
          danger_seen_next = (danger_seen && !first_q) || aircraft_hit;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= STEP_SQUARE;
      idx         <= '0;
      k           <= '0;
      danger_seen <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      idx         <= idx_next;
      k           <= k_next;
      danger_seen <= danger_seen_next;
      out_valid   <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ang[0]  <= la_lel - QTURN;
      ang[1]  <= la_ael - QTURN;
      ang[2]  <= la_lel;
      ang[3]  <= la_ael;
      ang[4]  <= la_laz - la_aaz;
      first_q <= in_ch.first_of_scan;
      last_q  <= in_ch.last_of_scan;
    end

    if (state == ST_ANGLE) begin
      qneg <= quad[0] ^ quad[1];
    end

    if ((state == ST_WAIT) && mul_rsp.done) begin
      case (step)
        STEP_SQUARE: begin
          u    <= mul_rsp.prod;
          op_a <= mul_rsp.prod;
          op_b <= cos_coef(K_W'(POLY_TOP));
        end
        STEP_HORNER: begin
          if (k != '0) begin
            op_a <= u;
            op_b <= p_new;
          end else begin
            // finished value shifts into the result line, next angle to the head
            for (int i = 0; i < N_ANGLES - 1; i++) begin
              res_mag[i] <= res_mag[i+1];
              res_neg[i] <= res_neg[i+1];
              ang[i]     <= ang[i+1];
            end
            res_mag[N_ANGLES-1] <= p_new;
            res_neg[N_ANGLES-1] <= qneg;
            op_a <= res_mag[1];
            op_b <= res_mag[2];
          end
        end
        STEP_PROD_S: begin
          s_mag <= mul_rsp.prod;
          s_neg <= res_neg[0] ^ res_neg[1];
          op_a  <= res_mag[2];
          op_b  <= res_mag[3];
        end
        STEP_PROD_C: begin
          c_neg <= res_neg[2] ^ res_neg[3];
          op_a  <= mul_rsp.prod;
          op_b  <= res_mag[4];
        end
        STEP_PROD_CC: begin
          c_mag <= mul_rsp.prod;
          c_neg <= c_neg ^ res_neg[4];
        end
        default: begin
        end
      endcase
    end

    if (state == ST_ROUND) begin
      sep <= sep_sat;
    end

    if (out_load) begin
      out_sep  <= sep;
      out_ad   <= aircraft_hit;
      out_sd   <= danger_seen_next;
      out_done <= last_q;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.separation_cos  = out_sep;
  assign out_ch.aircraft_danger = out_ad;
  assign out_ch.scan_danger     = out_sd;
  assign out_ch.scan_done       = out_done;

endmodule

// ----- rtl/core/laser_aircraft_cone_check.sv -----
`timescale 1ns / 1ps

// Laser to aircraft cone check. Each input transfer carries the laser and
// aircraft azimuth/elevation as binary fractions of a turn; one result
// transfer follows with the separation cosine (signed Q1.16, saturated to
// +-1.0), a flag set when it is strictly above cos_limit, the sticky
// per-scan danger flag (cleared by first_of_scan) and a copy of
// last_of_scan. cos_limit sits at byte address 0 of the APB port and resets
// to +1.0, so nothing is flagged until it is written. Items are handled one
// at a time: ready drops after an input transfer and returns only once the
// result has been loaded, which waits until the output register is free.
// Each item runs 33 multiplications (five degree-10 cosine polynomials plus
// three products) on the single shared 33x8-bit digit-serial multiplier,
// then rounding and the loading of the result. A finished result waits in
// its output register while the next item is taken.
module laser_aircraft_cone_check
  import lacc_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  lacc_in_if.sink               in_ch,
  lacc_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic signed [SEP_W-1:0] cos_limit;

  lacc_apb u_apb (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cos_limit (cos_limit)
  );

  lacc_core #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cos_limit (cos_limit)
  );

  // one item in flight: ready drops straight after an input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  // a new result only appears as the sequencer returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> in_ch.ready)
    else $error("result raised outside the end of an item");

  // a flagged aircraft always shows in the scan flag
  a_sticky_flag: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.aircraft_danger) |-> out_ch.scan_danger)
    else $error("aircraft flagged without scan danger");

  // saturation keeps the cosine within +-1.0
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.separation_cos <= SEP_ONE) &&
                      (out_ch.separation_cos >= -SEP_ONE)))
    else $error("separation cosine beyond +-1.0");

endmodule

// ----- dv/laser_aircraft_cone_check_tb.sv -----
`timescale 1ns / 1ps

module laser_aircraft_cone_check_tb;
  import lacc_pkg::*;

  localparam int ANGLE_RES   = ANGLE_BITS_DEF;
  localparam int RESET_CYC   = 11;
  localparam int TAIL_CYCLES = 250;   // a little over one item's latency
  localparam int STALL_LIMIT = 6000;  // cycles without any transfer
  localparam int PHASE_ITEMS = 430;

  localparam logic [63:0] TURN_MASK = (64'd1 << ANGLE_RES) - 64'd1;
  localparam logic [63:0] QUARTER   = 64'd1 << (ANGLE_RES - 2);

  localparam logic [PADDR_W-1:0] ADDR_COS_LIMIT = PADDR_W'(4 * int'(REG_COS_LIMIT));
  localparam logic [PADDR_W-1:0] ADDR_SPARE     = PADDR_W'(4 * (int'(REG_COS_LIMIT) + 1));

  typedef struct {
    logic        [15:0] laser_az;
    logic signed [15:0] laser_el;
    logic        [15:0] aircraft_az;
    logic signed [15:0] aircraft_el;
    logic               first_of_scan;
    logic               last_of_scan;
  } sighting_t;

  typedef struct {
    logic signed [SEP_W-1:0] separation_cos;
    logic                    aircraft_danger;
    logic                    scan_danger;
    logic                    scan_done;
  } cone_result_t;

  typedef struct {
    logic               cfg_en;
    logic [PADDR_W-1:0] cfg_addr;
    logic [31:0]        cfg_data;
    sighting_t          item;
    logic               typed;
    cone_result_t       result;
  } script_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lacc_in_if  in_ch ();
  lacc_out_if out_ch ();

  laser_aircraft_cone_check u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state and bookkeeping
  logic signed [SEP_W-1:0] cos_limit_model;
  logic                    scan_flag;
  cone_result_t            cone_results_due [$];
  script_row_t             script [$];
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      fault_count;
  int                      items_sent;
  int                      results_checked;
  int                      flagged_count;
  int                      limit_writes;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------

  function automatic logic [63:0] poly_coef(input int k);
    case (k)
      0:       return 64'd1073741824;
      1:       return 64'd1324675879;
      2:       return 64'd272375560;
      3:       return 64'd22401992;
      4:       return 64'd987048;
      default: return 64'd27061;
    endcase
  endfunction

  // 16-bit field to ANGLE_RES bits per turn
  function automatic logic [63:0] wrap_angle(input logic [15:0] v);
    logic [63:0] a;
    a = {48'd0, v};
    if (ANGLE_RES >= 16) a = a << (ANGLE_RES - 16);
    else a = a >> (16 - ANGLE_RES);
    return a & TURN_MASK;
  endfunction

  // cos over the first quadrant, Q30, Horner on t^2 with floor at zero
  function automatic logic [63:0] quadrant_cos(input logic [63:0] r);
    logic [63:0] t, u, p, m, c;
    int k;
    t = r << (32 - ANGLE_RES);
    u = (t * t) >> 30;
    p = poly_coef(5);
    for (k = 4; k >= 0; k--) begin
      m = (u * p) >> 30;
      c = poly_coef(k);
      p = (c > m) ? c - m : 64'd0;
    end
    return p;
  endfunction

  function automatic longint turn_cos(input logic [63:0] a);
    logic [63:0] q, r;
    q = (a & TURN_MASK) >> (ANGLE_RES - 2);
    r = a & (QUARTER - 64'd1);
    case (q[1:0])
      2'd0:    return longint'(quadrant_cos(r));
      2'd1:    return -longint'(quadrant_cos(QUARTER - r));
      2'd2:    return -longint'(quadrant_cos(r));
      default: return longint'(quadrant_cos(QUARTER - r));
    endcase
  endfunction

  function automatic longint turn_sin(input logic [63:0] a);
    return turn_cos((a - QUARTER) & TURN_MASK);
  endfunction

  // Signed Q30 product, truncated toward zero
  function automatic longint q30_mul(input longint a, input longint b);
    logic [63:0] ma, mb, m;
    logic        neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 64'(-a) : 64'(a);
    mb  = (b < 0) ? 64'(-b) : 64'(b);
    m   = (ma * mb) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Expected result of one sighting; advances the sticky scan flag
  function automatic cone_result_t predict_cone(input sighting_t s);
    logic [63:0]  laz, lel, aaz, ael;
    longint       sum, biased, sep;
    cone_result_t r;
    laz = wrap_angle(s.laser_az);
    lel = wrap_angle(s.laser_el);
    aaz = wrap_angle(s.aircraft_az);
    ael = wrap_angle(s.aircraft_el);
    sum = q30_mul(turn_sin(lel), turn_sin(ael))
        + q30_mul(q30_mul(turn_cos(lel), turn_cos(ael)),
                  turn_cos((laz - aaz) & TURN_MASK));
    // Bias keeps the value positive so the shift floors
    biased = sum + 64'sd4294967296 + 64'sd8192;
    sep    = (biased >>> 14) - 64'sd262144;
    if (sep > 64'sd65536) sep = 64'sd65536;
    if (sep < -64'sd65536) sep = -64'sd65536;
    r.separation_cos  = SEP_W'(sep);
    r.aircraft_danger = (sep > longint'(cos_limit_model));
    if (s.first_of_scan) scan_flag = 1'b0;
    if (r.aircraft_danger) scan_flag = 1'b1;
    r.scan_danger = scan_flag;
    r.scan_done   = s.last_of_scan;
    return r;
  endfunction

  // Random limit: mostly a narrow cone, sometimes any in-range or raw pattern
  function automatic logic [31:0] pick_limit();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($urandom_range(65536, 58000));
    if (sel < 80) return 32'($urandom_range(131072)) - 32'd65536;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Called just after a falling edge; returns just after a falling edge
  task automatic send_item(input sighting_t s, input logic typed,
                           input cone_result_t typed_res);
    cone_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.laser_az      <= s.laser_az;
    in_ch.laser_el      <= s.laser_el;
    in_ch.aircraft_az   <= s.aircraft_az;
    in_ch.aircraft_el   <= s.aircraft_el;
    in_ch.first_of_scan <= s.first_of_scan;
    in_ch.last_of_scan  <= s.last_of_scan;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_cone(s);
    if (typed) cone_results_due.push_back(typed_res);
    else cone_results_due.push_back(r);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (cone_results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write, then read back when it hits the limit register
  task automatic program_limit(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    logic readback;
    readback = (addr[PADDR_W-1:2] == REG_COS_LIMIT);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (readback) begin
      cos_limit_model = data[SEP_W-1:0];
      limit_writes++;
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (readback) begin
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      if (prdata[SEP_W-1:0] !== cos_limit_model) begin
        $display("%0t: cos_limit readback expected %0d got %0d", $time,
                 cos_limit_model, $signed(prdata[SEP_W-1:0]));
        fault_count++;
      end
      @(negedge clk);
      penable <= 1'b0;
    end
    psel <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_row(input logic cfg_en, input logic [PADDR_W-1:0] cfg_addr,
                         input logic [31:0] cfg_data,
                         input logic [15:0] laz, input logic [15:0] lel,
                         input logic [15:0] aaz, input logic [15:0] ael,
                         input logic first, input logic last, input logic typed,
                         input logic signed [SEP_W-1:0] sep, input logic ad,
                         input logic sd);
    script_row_t row;
    row.cfg_en                   = cfg_en;
    row.cfg_addr                 = cfg_addr;
    row.cfg_data                 = cfg_data;
    row.item.laser_az            = laz;
    row.item.laser_el            = lel;
    row.item.aircraft_az         = aaz;
    row.item.aircraft_el         = ael;
    row.item.first_of_scan       = first;
    row.item.last_of_scan        = last;
    row.typed                    = typed;
    row.result.separation_cos    = sep;
    row.result.aircraft_danger   = ad;
    row.result.scan_danger       = sd;
    row.result.scan_done         = last;
    script.push_back(row);
  endtask

  // Receiver stalls, decided at the falling edge
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: each result transfer against the oldest expectation
  always @(posedge clk) begin
    cone_result_t want;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (cone_results_due.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none got sep %0d",
                 $time, out_ch.separation_cos);
        fault_count++;
      end else begin
        want = cone_results_due.pop_front();
        results_checked++;
        if (want.aircraft_danger) flagged_count++;
        if (out_ch.separation_cos !== want.separation_cos) begin
          $display("%0t: separation_cos expected %0d got %0d", $time,
                   want.separation_cos, out_ch.separation_cos);
          fault_count++;
        end
        if (out_ch.aircraft_danger !== want.aircraft_danger) begin
          $display("%0t: aircraft_danger expected %0b got %0b", $time,
                   want.aircraft_danger, out_ch.aircraft_danger);
          fault_count++;
        end
        if (out_ch.scan_danger !== want.scan_danger) begin
          $display("%0t: scan_danger expected %0b got %0b", $time,
                   want.scan_danger, out_ch.scan_danger);
          fault_count++;
        end
        if (out_ch.scan_done !== want.scan_done) begin
          $display("%0t: scan_done expected %0b got %0b", $time,
                   want.scan_done, out_ch.scan_done);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("laser_aircraft_cone_check: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int           phase;
    int           phase_items;
    int           scan_len;
    int           j;
    int           sel;
    logic         broken;
    sighting_t    s;
    cone_result_t none;

    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.laser_az      = '0;
    in_ch.laser_el      = '0;
    in_ch.aircraft_az   = '0;
    in_ch.aircraft_el   = '0;
    in_ch.first_of_scan = 1'b0;
    in_ch.last_of_scan  = 1'b0;
    out_ch.ready        = 1'b0;
    send_idle_pct       = 23;
    recv_idle_pct       = 65;
    fault_count         = 0;
    items_sent          = 0;
    results_checked     = 0;
    flagged_count       = 0;
    limit_writes        = 0;
    cos_limit_model     = COS_LIMIT_RST;
    scan_flag           = 1'b0;
    none                = '{default: '0};

    // Directed table: cfg, addr, data | laz, lel, aaz, ael, first, last | typed, sep, ad, sd
    // Reset limit of +1.0: nothing flagged
    add_row(0, ADDR_COS_LIMIT, 0, 16'd0, 16'd0, 16'd0, 16'd0, 1, 0, 1, 65536, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd0, 16'd0, 16'd32768, 16'd0, 0, 0, 1, -65536, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd0, 16'd0, 16'd16384, 16'd0, 0, 1, 1, 0, 0, 0);
    // Limit -1.0: everything except the exact opposite direction
    add_row(1, ADDR_COS_LIMIT, 32'hFFFF_0000,
            16'd100, 16'd0, 16'd16484, 16'd0, 1, 0, 1, 0, 1, 1);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd100, 16'd0, 16'd32868, 16'd0, 0, 0, 1, -65536, 0, 1);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd100, 16'd0, 16'd32868, 16'd0, 1, 1, 1, -65536, 0, 0);
    // No first mark: flag keeps accumulating, also past a last mark
    add_row(0, ADDR_COS_LIMIT, 0, 16'd5000, 16'd0, 16'd5000, 16'd0, 0, 0, 1, 65536, 1, 1);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd5000, 16'd0, 16'd37768, 16'd0, 0, 1, 1, -65536, 0, 1);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd5000, 16'd0, 16'd37768, 16'd0, 0, 0, 1, -65536, 0, 1);
    // Just below +1.0 flags an exact hit
    add_row(1, ADDR_COS_LIMIT, 32'h0000_FFFF,
            16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1, 0, 1, 65536, 1, 1);
    // Limit beyond range on both sides, compared as is
    add_row(1, ADDR_COS_LIMIT, 32'h0001_FFFF,
            16'd0, 16'd0, 16'd0, 16'd0, 1, 0, 1, 65536, 0, 0);
    add_row(1, ADDR_COS_LIMIT, 32'hFFFE_0000,
            16'd0, 16'd0, 16'd32768, 16'd0, 1, 0, 1, -65536, 1, 1);
    // Elevation extremes
    add_row(1, ADDR_COS_LIMIT, 32'h0001_0000,
            16'd1234, 16'h4000, 16'd40000, 16'h4000, 1, 0, 1, 65536, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd0, 16'h4000, 16'd0, 16'hC000, 0, 1, 1, -65536, 0, 0);
    // Predicted rows: elevation out of range, field extremes, near misses
    add_row(1, ADDR_COS_LIMIT, 32'h0000_0000,
            16'hFFFF, 16'hC000, 16'd0, 16'h4000, 1, 0, 0, 0, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd12345, 16'h8000, 16'd54321, 16'h7FFF, 0, 0, 0, 0, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h8000, 0, 0, 0, 0, 0, 0);
    add_row(1, ADDR_COS_LIMIT, 32'd46341,
            16'd1000, 16'd2000, 16'd1500, 16'd2500, 1, 0, 0, 0, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd1000, 16'd2000, 16'd1010, 16'd1990, 0, 0, 0, 0, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'd40000, 16'hFED4, 16'd8000, 16'd12000, 0, 1, 0, 0, 0, 0);
    // Write past the register list is ignored
    add_row(1, ADDR_SPARE, 32'h0000_5A5A,
            16'd7, 16'd8, 16'd9, 16'd10, 1, 0, 0, 0, 0, 0);
    add_row(0, ADDR_COS_LIMIT, 0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 0, 1, 0, 0, 0, 0);

    // Single reset at the start
    repeat (RESET_CYC) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      if (script[i].cfg_en) begin
        drain_results();
        program_limit(script[i].cfg_addr, script[i].cfg_data);
      end
      send_item(script[i].item, script[i].typed, script[i].result);
    end

    // Random scans in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      program_limit(ADDR_COS_LIMIT, pick_limit());
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // Occasional new limit or a full pause between scans
        if ($urandom_range(19) == 0) begin
          drain_results();
          program_limit(ADDR_COS_LIMIT, pick_limit());
        end else if ($urandom_range(9) == 0) begin
          drain_results();
        end
        scan_len = $urandom_range(12, 1);
        broken   = ($urandom_range(99) < 15);
        for (j = 0; j < scan_len; j++) begin
          s.laser_az = 16'($urandom);
          s.laser_el = 16'($urandom_range(32768) - 16384);
          sel        = $urandom_range(99);
          if (sel < 55) begin
            // aircraft close to the beam
            s.aircraft_az = s.laser_az + 16'($urandom_range(4095)) - 16'd2048;
            s.aircraft_el = s.laser_el + 16'($urandom_range(4095)) - 16'sd2048;
          end else if (sel < 85) begin
            s.aircraft_az = 16'($urandom);
            s.aircraft_el = 16'($urandom_range(32768) - 16384);
          end else begin
            s.laser_el    = 16'($urandom);
            s.aircraft_az = 16'($urandom);
            s.aircraft_el = 16'($urandom);
          end
          s.first_of_scan = (j == 0);
          s.last_of_scan  = (j == scan_len - 1);
          if (broken) begin
            s.first_of_scan = 1'($urandom_range(1));
            s.last_of_scan  = 1'($urandom_range(1));
          end
          send_item(s, 1'b0, none);
          phase_items++;
        end
      end
    end

    // Wait out the remaining results, then a latency's worth of quiet
    in_ch.valid <= 1'b0;
    while (cone_results_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d aircraft over three idling phases, %0d limit settings.",
             items_sent, limit_writes);
    $display("Checked %0d results, %0d of them inside the cone.",
             results_checked, flagged_count);
    if (fault_count == 0 && cone_results_due.size() == 0)
      $display("laser_aircraft_cone_check: match");
    else
      $display("laser_aircraft_cone_check: mismatch");
    $finish;
  end

endmodule
